// ----- hw/rtl/sha_pkg.sv -----
// ----------------------------------------------------------------------------
// sha_pkg
// Types, constants and round constant table for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] hash_t;
  typedef word_t [15:0] window_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ROUND = 5'b00010,
    ST_ADD   = 5'b00100,
    ST_PAD   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  typedef struct packed {
    window_t words;
    logic    extra_block;
  } pad_res_t;

  localparam hash_t HASH_INIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [5:0] LAST_BYTE  = 6'd63;
  localparam logic [5:0] PAD_LIMIT  = 6'd56;
  localparam logic [2:0] LAST_WORD  = 3'd7;
  localparam logic [7:0] PAD_MARK   = 8'h80;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    unique case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

// ----- hw/rtl/sha_if.sv -----
// ----------------------------------------------------------------------------
// sha_in_if / sha_out_if
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source(output valid, msg_byte, has_byte, end_of_message, input ready);
  modport sink(input valid, msg_byte, has_byte, end_of_message, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        digest_last;

  modport source(output valid, digest_word, word_index, digest_last, input ready);
  modport sink(input valid, digest_word, word_index, digest_last, output ready);
endinterface

// ----- hw/rtl/sha_round.sv -----
// ----------------------------------------------------------------------------
// sha_round
// One SHA-256 compression round plus the next message schedule word.
// ----------------------------------------------------------------------------
module sha_round (
  input  sha_pkg::hash_t   v,
  input  sha_pkg::window_t w,
  input  sha_pkg::word_t   k,
  output sha_pkg::hash_t   v_next,
  output sha_pkg::word_t   w_new
);
  import sha_pkg::*;

  word_t big1, ch, t1, big0, maj, t2, sig0, sig1;

  always_comb begin
    big1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch   = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1   = v[7] + big1 + ch + k + w[0];
    big0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    maj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2   = big0 + maj;

    v_next[0] = t1 + t2;
    v_next[1] = v[0];
    v_next[2] = v[1];
    v_next[3] = v[2];
    v_next[4] = v[3] + t1;
    v_next[5] = v[4];
    v_next[6] = v[5];
    v_next[7] = v[6];

    sig0  = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    sig1  = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = sig1 + w[9] + sig0 + w[0];
  end

endmodule

// ----- hw/rtl/sha_pad.sv -----
// ----------------------------------------------------------------------------
// sha_pad
// Builds a padded block: end marker, zero fill and, when it fits, the 64-bit bit length.
// ----------------------------------------------------------------------------
module sha_pad (
  input  sha_pkg::window_t w,
  input  logic [5:0]       fill,
  input  logic             marker_done,
  input  logic [63:0]      bit_len,
  output sha_pkg::pad_res_t res
);
  import sha_pkg::*;

  always_comb begin
    logic [5:0] pos;
    pos = '0;
    res.words = w;
    for (int j = 0; j < 16; j++) begin
      for (int b = 0; b < 4; b++) begin
        pos = 6'(j * 4 + b);
        if (marker_done || pos > fill) begin
          res.words[j][8*(3-b) +: 8] = 8'h00;
        end else if (pos == fill) begin
          res.words[j][8*(3-b) +: 8] = PAD_MARK;
        end
      end
    end
    // marker lands in the length field: length goes in a further block
    res.extra_block = !marker_done && (fill >= PAD_LIMIT);
    if (!res.extra_block) begin
      res.words[14] = bit_len[63:32];
      res.words[15] = bit_len[31:0];
    end
  end

endmodule

// ----- hw/rtl/sha256_stream_hasher_unit.sv -----
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit
// Byte-stream SHA-256 with one shared round unit under a small sequencer.
// ----------------------------------------------------------------------------
// Flow: one byte per cycle while idle; a byte that completes a block starts 64 rounds
//   through the single round unit, then a chaining add; no byte is taken meanwhile.
// End mark: a pad step, the rounds and the add, again when padding spills into a
//   second block, then 8 digest words, one per cycle while the sink is ready.
// Throughput is set by the shared round unit: input is ready only in idle.
// Reset: synchronous, active low; initial hash and zero byte count, no clearing pass.
module sha256_stream_hasher_unit (
  input  logic   clk,
  input  logic   rst_n,
  sha_in_if.sink    in_ch,
  sha_out_if.source out_ch
);
  import sha_pkg::*;

  state_t      state_r, state_nxt;
  hash_t       chain_r, chain_nxt;
  hash_t       v_r, v_nxt;
  window_t     w_r, w_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [63:0] byte_total_r, byte_total_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        pend_pad_r, pend_pad_nxt;
  logic        final_r, final_nxt;
  logic        marker_r, marker_nxt;

  hash_t       v_round;
  word_t       w_new;
  pad_res_t    pad_res;
  logic [5:0]  fill;

  assign fill = byte_total_r[5:0];

  sha_round u_round (
    .v      (v_r),
    .w      (w_r),
    .k      (round_k(rnd_r)),
    .v_next (v_round),
    .w_new  (w_new)
  );

  sha_pad u_pad (
    .w           (w_r),
    .fill        (fill),
    .marker_done (marker_r),
    .bit_len     ({byte_total_r[60:0], 3'b000}),
    .res         (pad_res)
  );

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = (state_r == ST_EMIT);
  assign out_ch.digest_word = chain_r[idx_r];
  assign out_ch.word_index  = idx_r;
  assign out_ch.digest_last = (idx_r == LAST_WORD);

  always_comb begin
    state_nxt      = state_r;
    chain_nxt      = chain_r;
    v_nxt          = v_r;
    w_nxt          = w_r;
    rnd_nxt        = rnd_r;
    byte_total_nxt = byte_total_r;
    idx_nxt        = idx_r;
    pend_pad_nxt   = pend_pad_r;
    final_nxt      = final_r;
    marker_nxt     = marker_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.has_byte) begin
            unique case (fill[1:0])
              2'd0: w_nxt[fill[5:2]][31:24] = in_ch.msg_byte;
              2'd1: w_nxt[fill[5:2]][23:16] = in_ch.msg_byte;
              2'd2: w_nxt[fill[5:2]][15:8]  = in_ch.msg_byte;
              2'd3: w_nxt[fill[5:2]][7:0]   = in_ch.msg_byte;
            endcase
            byte_total_nxt = byte_total_r + 64'd1;
            if (fill == LAST_BYTE) begin
              state_nxt    = ST_ROUND;
              v_nxt        = chain_r;
              rnd_nxt      = '0;
              pend_pad_nxt = in_ch.end_of_message;
              final_nxt    = 1'b0;
            end else if (in_ch.end_of_message) begin
              state_nxt = ST_PAD;
            end
          end else if (in_ch.end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        v_nxt = v_round;
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[15] = w_new;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == LAST_ROUND) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < 8; i++) begin
          chain_nxt[i] = chain_r[i] + v_r[i];
        end
        if (final_r) begin
          state_nxt = ST_EMIT;
          idx_nxt   = '0;
        end else if (pend_pad_r) begin
          state_nxt    = ST_PAD;
          pend_pad_nxt = 1'b0;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PAD: begin
        w_nxt     = pad_res.words;
        v_nxt     = chain_r;
        rnd_nxt   = '0;
        state_nxt = ST_ROUND;
        if (pad_res.extra_block) begin
          marker_nxt   = 1'b1;
          pend_pad_nxt = 1'b1;
          final_nxt    = 1'b0;
        end else begin
          pend_pad_nxt = 1'b0;
          final_nxt    = 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_ch.ready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == LAST_WORD) begin
            state_nxt      = ST_IDLE;
            chain_nxt      = HASH_INIT;
            byte_total_nxt = '0;
            marker_nxt     = 1'b0;
            final_nxt      = 1'b0;
            pend_pad_nxt   = 1'b0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      chain_r      <= HASH_INIT;
      rnd_r        <= '0;
      byte_total_r <= '0;
      idx_r        <= '0;
      pend_pad_r   <= 1'b0;
      final_r      <= 1'b0;
      marker_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      chain_r      <= chain_nxt;
      rnd_r        <= rnd_nxt;
      byte_total_r <= byte_total_nxt;
      idx_r        <= idx_nxt;
      pend_pad_r   <= pend_pad_nxt;
      final_r      <= final_nxt;
      marker_r     <= marker_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
    w_r <= w_nxt;
  end

endmodule

// ----- hw/rtl/sha_checker.sv -----
// ----------------------------------------------------------------------------
// sha_checker
// Port-level checks on the hasher: digest burst shape and channel exclusion.
// ----------------------------------------------------------------------------
module sha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_digest_last
);
  import sha_pkg::*;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while digest words pending");

  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_digest_last) |=>
      (out_valid && out_word_index == $past(out_word_index) + 3'd1))
    else $error("digest burst broken before last word");

  a_burst_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_digest_last) |=> (!out_valid && in_ready))
    else $error("no return to input after last digest word");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_digest_word) && $stable(out_word_index)))
    else $error("stalled digest transfer changed");

  a_in_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> !out_valid)
    else $error("input transfer during digest output");

endmodule

bind sha256_stream_hasher_unit sha_checker u_sha_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_digest_word (out_ch.digest_word),
  .out_word_index  (out_ch.word_index),
  .out_digest_last (out_ch.digest_last)
);
